FILE: sv/ast_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants of the assembly source tokeniser.
// ----------------------------------------------------------------------------
package ast_pkg;

	localparam int AST_POS_WIDTH = 16;
	localparam int AST_Q_DEPTH   = 3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_AT    = 8'h40;

	typedef enum logic [3:0] {
		M_IDLE,
		M_COMMENT,
		M_REG_EMPTY,
		M_REG,
		M_LAB_EMPTY,
		M_LAB,
		M_WORD,
		M_NUM_INT,
		M_NUM_FRAC,
		M_NEWLINE,
		M_ERROR
	} scan_mode_t;

	typedef enum logic [2:0] {
		TK_END,
		TK_NUMBER,
		TK_REGISTER,
		TK_NEWLINE,
		TK_WORD,
		TK_LABEL,
		TK_ERROR
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_EMPTY_NAME,
		ERR_INVALID
	} err_kind_t;

	typedef struct packed {
		logic        last;
		logic [15:0] len;
		logic [15:0] col;
		logic [15:0] line;
		err_kind_t   err;
		tok_kind_t   kind;
	} ast_result_t;

	typedef struct packed {
		logic [1:0]  count;
		ast_result_t first;
		ast_result_t second;
	} ast_push_t;

endpackage
`default_nettype wire

FILE: sv/assembly_source_tokenizer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_core
// Byte-stream tokeniser for assembly source: positions, kinds and lengths.
// ----------------------------------------------------------------------------
// A byte taken is held in an input register and scanned; its results are
// registered in the result queue. One byte per cycle while each byte gives
// at most one result and m_tready stays high; a byte giving two results can
// stall the input, as the single-word output port drains the three-entry result queue.
// Reset: arst_n clears the scanner to line 0, column 0 and empties the queue.
module assembly_source_tokenizer_core
	import ast_pkg::*;
#(
	parameter int POS_WIDTH = AST_POS_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // char_code
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // token_kind, error_kind, start_line, start_col, token_length
	output logic             m_tlast    // last_of_run
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        fire, room;
	ast_push_t   push;
	ast_result_t head;

	assign fire     = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
		end
	end

	ast_scan #(
		.POS_WIDTH(POS_WIDTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.char_code(char_s1),
		.push     (push)
	);

	ast_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.take      (m_tready),
		.head      (head),
		.head_valid(m_tvalid),
		.room      (room)
	);

	assign m_tdata = {3'b000, head.len, head.col, head.line, head.err, head.kind};
	assign m_tlast = head.last;

endmodule
`default_nettype wire

FILE: sv/ast_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ast_scan
// Scanner state and per-byte classification; yields up to two results a byte.
// ----------------------------------------------------------------------------
module ast_scan
	import ast_pkg::*;
#(
	parameter int POS_WIDTH = AST_POS_WIDTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] char_code,
	output ast_push_t       push
);

	localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

	scan_mode_t           mode_q, mode_d;
	logic [POS_WIDTH-1:0] line_q, line_d, col_q, col_d;
	logic [POS_WIDTH-1:0] tline_q, tline_d, tcol_q, tcol_d, tlen_q, tlen_d;
	logic [POS_WIDTH-1:0] adv_line, adv_col;
	logic                 a_v, b_v, go, do_reset;
	tok_kind_t            a_kind, b_kind;
	err_kind_t            a_err, b_err;
	logic [POS_WIDTH-1:0] b_line, b_col, b_len;
	ast_result_t          res_a, res_b;
	logic                 is_digit, is_letter, is_alnum;

	function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	always_comb begin
		is_digit  = char_code inside {[8'h30:8'h39]};
		is_letter = char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]};
		is_alnum  = is_digit || is_letter;
		adv_line  = (char_code == CH_LF) ? sat_inc(line_q) : line_q;
		adv_col   = (char_code == CH_LF) ? '0 : sat_inc(col_q);

		mode_d   = mode_q;
		line_d   = line_q;
		col_d    = col_q;
		tline_d  = tline_q;
		tcol_d   = tcol_q;
		tlen_d   = tlen_q;
		a_v      = 1'b0;
		a_kind   = TK_END;
		a_err    = ERR_NONE;
		b_v      = 1'b0;
		b_kind   = TK_END;
		b_err    = ERR_NONE;
		b_line   = line_q;
		b_col    = col_q;
		b_len    = '0;
		go       = 1'b0;
		do_reset = 1'b0;

		case (mode_q)
			M_ERROR: begin
				if (char_code == CH_NUL) begin
					do_reset = 1'b1;
				end else begin
					line_d = adv_line;
					col_d  = adv_col;
				end
			end
			M_REG_EMPTY, M_LAB_EMPTY: begin
				if (is_alnum) begin
					mode_d = (mode_q == M_REG_EMPTY) ? M_REG : M_LAB;
					tlen_d = sat_inc(tlen_q);
					line_d = adv_line;
					col_d  = adv_col;
				end else begin
					a_v    = 1'b1;
					a_kind = TK_ERROR;
					a_err  = ERR_EMPTY_NAME;
					if (char_code == CH_NUL) begin
						do_reset = 1'b1;
					end else begin
						mode_d = M_ERROR;
						line_d = adv_line;
						col_d  = adv_col;
					end
				end
			end
			M_REG, M_LAB, M_WORD: begin
				if (is_alnum) begin
					tlen_d = sat_inc(tlen_q);
					line_d = adv_line;
					col_d  = adv_col;
				end else begin
					a_v    = 1'b1;
					a_kind = (mode_q == M_REG) ? TK_REGISTER :
					         (mode_q == M_LAB) ? TK_LABEL : TK_WORD;
					go     = 1'b1;
				end
			end
			M_NUM_INT, M_NUM_FRAC: begin
				if (is_digit || (mode_q == M_NUM_INT && char_code == CH_DOT)) begin
					if (!is_digit) begin
						mode_d = M_NUM_FRAC;
					end
					tlen_d = sat_inc(tlen_q);
					line_d = adv_line;
					col_d  = adv_col;
				end else begin
					a_v    = 1'b1;
					a_kind = TK_NUMBER;
					go     = 1'b1;
				end
			end
			M_NEWLINE: begin
				a_v    = 1'b1;
				a_kind = TK_NEWLINE;
				go     = 1'b1;
			end
			M_COMMENT: begin
				if (char_code != CH_LF && char_code != CH_NUL) begin
					line_d = adv_line;
					col_d  = adv_col;
				end else begin
					go = 1'b1;
				end
			end
			default: begin
				go = 1'b1;
			end
		endcase

		if (go) begin
			mode_d = M_IDLE;
			if (char_code == CH_NUL) begin
				b_v      = (line_q != '0) || (col_q != '0);
				do_reset = 1'b1;
			end else if (char_code == CH_SP || char_code == CH_TAB || char_code == CH_CR) begin
				line_d = adv_line;
				col_d  = adv_col;
			end else if (char_code == CH_SEMI) begin
				mode_d = M_COMMENT;
				line_d = adv_line;
				col_d  = adv_col;
			end else if (char_code == CH_PCT || char_code == CH_AT || char_code == CH_LF ||
			             char_code == CH_MINUS || is_digit || is_letter) begin
				if (char_code == CH_PCT) begin
					mode_d = M_REG_EMPTY;
				end else if (char_code == CH_AT) begin
					mode_d = M_LAB_EMPTY;
				end else if (char_code == CH_LF) begin
					mode_d = M_NEWLINE;
				end else if (is_letter) begin
					mode_d = M_WORD;
				end else begin
					mode_d = M_NUM_INT;
				end
				tline_d = line_q;
				tcol_d  = col_q;
				tlen_d  = POS_WIDTH'(1);
				line_d  = adv_line;
				col_d   = adv_col;
			end else begin
				b_v    = 1'b1;
				b_kind = TK_ERROR;
				b_err  = ERR_INVALID;
				b_len  = POS_WIDTH'(1);
				mode_d = M_ERROR;
				line_d = adv_line;
				col_d  = adv_col;
			end
		end

		if (do_reset) begin
			mode_d  = M_IDLE;
			line_d  = '0;
			col_d   = '0;
			tline_d = '0;
			tcol_d  = '0;
			tlen_d  = '0;
		end

		res_a.last = !b_v;
		res_a.len  = 16'(tlen_q);
		res_a.col  = 16'(tcol_q);
		res_a.line = 16'(tline_q);
		res_a.err  = a_err;
		res_a.kind = a_kind;
		res_b.last = 1'b1;
		res_b.len  = 16'(b_len);
		res_b.col  = 16'(b_col);
		res_b.line = 16'(b_line);
		res_b.err  = b_err;
		res_b.kind = b_kind;

		push.count  = {1'b0, a_v} + {1'b0, b_v};
		push.first  = a_v ? res_a : res_b;
		push.second = res_b;
		if (!fire) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			line_q  <= '0;
			col_q   <= '0;
			tline_q <= '0;
			tcol_q  <= '0;
			tlen_q  <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			line_q  <= line_d;
			col_q   <= col_d;
			tline_q <= tline_d;
			tcol_q  <= tcol_d;
			tlen_q  <= tlen_d;
		end
	end

endmodule
`default_nettype wire

FILE: sv/ast_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ast_outq
// Three-entry result queue taking up to two words a cycle; pops one on take.
// ----------------------------------------------------------------------------
module ast_outq
	import ast_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire ast_push_t push,
	input  wire logic  take,
	output ast_result_t head,
	output logic       head_valid,
	output logic       room
);

	ast_result_t slot_q [AST_Q_DEPTH];
	ast_result_t slot_d [AST_Q_DEPTH];
	logic [1:0]  cnt_q, cnt_d, cnt_pop;
	logic        pop;

	always_comb begin
		pop     = (cnt_q != 2'd0) && take;
		cnt_pop = cnt_q - {1'b0, pop};
		cnt_d   = cnt_pop + push.count;
		for (int i = 0; i < AST_Q_DEPTH; i++) begin
			slot_d[i] = slot_q[i];
		end
		for (int i = 0; i < AST_Q_DEPTH - 1; i++) begin
			if (pop) begin
				slot_d[i] = slot_q[i+1];
			end
		end
		for (int i = 0; i < AST_Q_DEPTH; i++) begin
			if (push.count != 2'd0 && 2'(i) == cnt_pop) begin
				slot_d[i] = push.first;
			end else if (push.count == 2'd2 && 2'(i) == cnt_pop + 2'd1) begin
				slot_d[i] = push.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < AST_Q_DEPTH; i++) begin
			slot_q[i] <= slot_d[i];
		end
	end

	assign head       = slot_q[0];
	assign head_valid = (cnt_q != 2'd0);
	assign room       = (cnt_q <= 2'd1);

endmodule
`default_nettype wire
